[hdl/teq_pkg.sv]
// ----------------------------------------------------------------------------
// teq_pkg
// Shared widths, command and status codes, and the controller/datapath
// interface types of the time-ordered event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int CMD_W         = 3;
   localparam int TIME_W        = 32;
   localparam int ID_W          = 16;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      RD_AT_PTR,
      RD_BELOW_PTR,
      RD_ABOVE_PTR
   } rd_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD_COUNT,
      PTR_CLEAR,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef struct packed {
      logic                capture;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      logic                wr_new;
      ptr_op_type          ptr_op;
      logic                count_inc;
      logic                count_dec;
      logic                flag_set;
      logic                head_load;
      logic                head_clear;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             past_end;
      logic             full;
      logic             list_empty;
      logic             ptr_zero;
      logic             ptr_last;
      logic             later;
      logic             id_match;
      logic             rsp_free;
   } ctrl_stat_type;

endpackage

[hdl/teq_ctrl.sv]
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer of the event queue: decodes one command and steps the datapath
// through the walk, search and shift over the slot memory.
// ----------------------------------------------------------------------------
module teq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  teq_pkg::ctrl_stat_type         stat,
   output teq_pkg::ctrl_cmd_type          cmd
);
   import teq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_CHK,
      S_HEAD_RD,
      S_HEAD_CAP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_AT_PTR;
      cmd.ptr_op     = PTR_HOLD;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.head_clear = 1'b1;
            status_in      = ST_OK;
            state_in       = S_DONE;
            case (stat.op)
               CMD_INSERT: begin
                  if (stat.past_end) begin
                     status_in = ST_DROPPED;
                  end else if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_COUNT;
                     state_in   = S_INS_RD;
                  end
               end
               CMD_POP, CMD_PEEK: begin
                  if (stat.list_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.ptr_op = PTR_CLEAR;
                     state_in   = S_HEAD_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.list_empty) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     cmd.ptr_op = PTR_CLEAR;
                     state_in   = S_SRCH_RD;
                  end
               end
               CMD_EMPTY: begin
                  cmd.flag_set = 1'b1;
               end
               default: begin
               end
            endcase
         end
         // walk from the tail toward the head, moving later entries up
         S_INS_RD: begin
            if (stat.ptr_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW_PTR;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            cmd.wr_en = 1'b1;
            if (stat.later) begin
               cmd.ptr_op = PTR_DEC;
               state_in   = S_INS_RD;
            end else begin
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_HEAD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_HEAD_CAP;
         end
         S_HEAD_CAP: begin
            cmd.head_load = 1'b1;
            if (stat.op == CMD_POP) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         // close the gap at ptr by moving the rest down one slot
         S_SHIFT_RD: begin
            if (stat.ptr_last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE_PTR;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
            state_in   = S_SHIFT_RD;
         end
         S_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (stat.id_match) begin
               state_in = S_SHIFT_RD;
            end else if (stat.ptr_last) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_SRCH_RD;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/teq_dpath.sv]
// ----------------------------------------------------------------------------
// teq_dpath
// Datapath of the event queue: slot memory with registered read, entry
// count, walk pointer, end-time register and the result register.
// ----------------------------------------------------------------------------
module teq_dpath #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  teq_pkg::ctrl_cmd_type                  cmd,
   output teq_pkg::ctrl_stat_type                 stat,
   input  logic [teq_pkg::CMD_W-1:0]              req_command,
   input  logic [teq_pkg::TIME_W-1:0]             req_event_time,
   input  logic [teq_pkg::ID_W-1:0]               req_event_id,
   input  logic                                   csr_write_en,
   input  logic [teq_pkg::TIME_W-1:0]             csr_write_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [teq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [teq_pkg::TIME_W-1:0]             rsp_head_time,
   output logic [teq_pkg::ID_W-1:0]               rsp_head_id,
   output logic                                   rsp_is_empty,
   output logic [teq_pkg::ENTRY_COUNT_W-1:0]      rsp_entry_count
);
   import teq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   logic [TIME_W-1:0]   mem_time_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]     mem_id_ff   [QUEUE_DEPTH];

   logic [CMD_W-1:0]    op_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TIME_W-1:0]   end_time_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic                flag_ff;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       rd_addr;
   logic [TIME_W-1:0]   rd_time_ff;
   logic [ID_W-1:0]     rd_id_ff;
   logic [TIME_W-1:0]   head_time_ff;
   logic [ID_W-1:0]     head_id_ff;
   logic [CW-1:0]       ptr_next_pos;
   logic [CW+ENTRY_COUNT_W-1:0] count_ext;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [TIME_W-1:0]         rsp_head_time_ff;
   logic [ID_W-1:0]           rsp_head_id_ff;
   logic                      rsp_is_empty_ff;
   logic [ENTRY_COUNT_W-1:0]  rsp_entry_count_ff;

   // captured word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_command;
         time_ff <= req_event_time;
         id_ff   <= req_event_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_time_ff <= '1;
      end else if (csr_write_en) begin
         end_time_ff <= csr_write_data;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW_PTR: rd_addr = ptr_ff - AW'(1);
         RD_ABOVE_PTR: rd_addr = ptr_ff + AW'(1);
         default:      rd_addr = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_time_ff[ptr_ff] <= cmd.wr_new ? time_ff : rd_time_ff;
         mem_id_ff[ptr_ff]   <= cmd.wr_new ? id_ff : rd_id_ff;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= mem_time_ff[rd_addr];
         rd_id_ff   <= mem_id_ff[rd_addr];
      end
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_LOAD_COUNT: ptr_in = count_ff[AW-1:0];
         PTR_CLEAR:      ptr_in = '0;
         PTR_INC:        ptr_in = ptr_ff + AW'(1);
         PTR_DEC:        ptr_in = ptr_ff - AW'(1);
         default:        ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (cmd.flag_set) begin
            flag_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_clear) begin
         head_time_ff <= '0;
         head_id_ff   <= '0;
      end else if (cmd.head_load) begin
         head_time_ff <= rd_time_ff;
         head_id_ff   <= rd_id_ff;
      end
   end

   assign ptr_next_pos = CW'(ptr_ff) + CW'(1);
   assign count_ext    = {{ENTRY_COUNT_W{1'b0}}, count_ff};

   assign stat.op         = op_ff;
   assign stat.past_end   = (time_ff > end_time_ff);
   assign stat.full       = (count_ff >= DEPTH_C);
   assign stat.list_empty = (count_ff == '0);
   assign stat.ptr_zero   = (ptr_ff == '0);
   assign stat.ptr_last   = (ptr_next_pos >= count_ff);
   assign stat.later      = (rd_time_ff > time_ff);
   assign stat.id_match   = (rd_id_ff == id_ff);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // result register, refilled once the previous word has gone
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff      <= cmd.rsp_status;
         rsp_head_time_ff   <= head_time_ff;
         rsp_head_id_ff     <= head_id_ff;
         rsp_is_empty_ff    <= flag_ff || (count_ff == '0);
         rsp_entry_count_ff <= count_ext[ENTRY_COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_time   = rsp_head_time_ff;
   assign rsp_head_id     = rsp_head_id_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

[hdl/time_ordered_event_queue.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Depth-limited queue of (time, id) events kept in ascending time order.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives one result word. The slots
// sit in one memory with a registered read port, so every entry examined or
// moved takes a read state and then a write or check state. An insert moves
// each entry later than the new one up, a pop reads the head and shifts the
// rest down, a remove searches by id and shifts the entries above a match
// down, a peek reads only the head, and mark-emptied, unused and rejected
// commands go straight to their result. A result still waiting in the output
// register holds the command in its done state until that word has gone.
// req_stall is high while a command is in work; the next word can be taken
// while a result still waits in the output register. The slot memory needs
// no clearing after reset.
module time_ordered_event_queue #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [teq_pkg::CMD_W-1:0]         req_command,
   input  logic [teq_pkg::TIME_W-1:0]        req_event_time,
   input  logic [teq_pkg::ID_W-1:0]          req_event_id,
   input  logic                              csr_write_en,
   input  logic [teq_pkg::TIME_W-1:0]        csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [teq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [teq_pkg::TIME_W-1:0]        rsp_head_time,
   output logic [teq_pkg::ID_W-1:0]          rsp_head_id,
   output logic                              rsp_is_empty,
   output logic [teq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import teq_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   teq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   teq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_event_time  (req_event_time),
      .req_event_id    (req_event_id),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_head_time   (rsp_head_time),
      .rsp_head_id     (rsp_head_id),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

[hdl/teq_checker.sv]
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the event queue, bound to the top level.
// ----------------------------------------------------------------------------
module teq_checker #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [teq_pkg::STATUS_W-1:0]      rsp_status,
   input logic [teq_pkg::TIME_W-1:0]        rsp_head_time,
   input logic [teq_pkg::ID_W-1:0]          rsp_head_id,
   input logic                              rsp_is_empty,
   input logic [teq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import teq_pkg::*;

   localparam bit COUNT_FITS = (QUEUE_DEPTH < 32);

   // a taken command word keeps the input stalled while it is in work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a command word was taken");

   // a waiting result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a new result only follows a command in work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without a command in work");

   // head fields are zero on any failed command
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_head_time == '0) && (rsp_head_id == '0))
      else $error("head fields set on a failed command");

   // empty reports agree with the entry count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || (COUNT_FITS && rsp_entry_count == '0))
      |-> rsp_is_empty && (rsp_status != ST_EMPTY || rsp_entry_count == '0))
      else $error("empty flag disagrees with entry count");

endmodule

bind time_ordered_event_queue teq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_teq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_head_time   (rsp_head_time),
   .rsp_head_id     (rsp_head_id),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_entry_count (rsp_entry_count)
);

[tb/sv/time_ordered_event_queue_checker.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue_checker
// Watches the command, result and register ports of the event queue, keeps
// its own sorted copy of the stored events and checks every result word in
// order against the outcome predicted when the command word was taken.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_checker #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [teq_pkg::CMD_W-1:0]         req_command,
   input  logic [teq_pkg::TIME_W-1:0]        req_event_time,
   input  logic [teq_pkg::ID_W-1:0]          req_event_id,
   input  logic                              csr_write_en,
   input  logic [teq_pkg::TIME_W-1:0]        csr_write_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [teq_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [teq_pkg::TIME_W-1:0]        rsp_head_time,
   input  logic [teq_pkg::ID_W-1:0]          rsp_head_id,
   input  logic                              rsp_is_empty,
   input  logic [teq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   output int                                mismatches,
   output int                                outstanding
);
   import teq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [TIME_W-1:0]        head_time;
      logic [ID_W-1:0]          head_id;
      logic                     is_empty;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } outcome_type;

   logic [TIME_W-1:0] ev_time [QUEUE_DEPTH];
   logic [ID_W-1:0]   ev_id   [QUEUE_DEPTH];
   int                held;
   logic              emptied;
   logic [TIME_W-1:0] horizon;
   outcome_type       awaited_outcomes[$];
   int                words_seen;

   function automatic void close_gap(input int pos);
      for (int i = pos; i + 1 < held; i++) begin
         ev_time[i] = ev_time[i+1];
         ev_id[i]   = ev_id[i+1];
      end
      held--;
   endfunction

   function automatic outcome_type schedule_step(input logic [CMD_W-1:0] cmd,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic [ID_W-1:0] id);
      outcome_type o;
      int          pos;
      o = '0;
      case (cmd)
         CMD_INSERT: begin
            // end-time check wins over the full check
            if (t > horizon) begin
               o.status = ST_DROPPED;
            end else if (held >= QUEUE_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               // equal times keep arrival order
               pos = held;
               while (pos > 0 && ev_time[pos-1] > t) begin
                  ev_time[pos] = ev_time[pos-1];
                  ev_id[pos]   = ev_id[pos-1];
                  pos--;
               end
               ev_time[pos] = t;
               ev_id[pos]   = id;
               held++;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (held == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.head_time = ev_time[0];
               o.head_id   = ev_id[0];
               if (cmd == CMD_POP) close_gap(0);
            end
         end
         CMD_REMOVE: begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < held; i++) begin
               if (ev_id[i] == id) begin
                  close_gap(i);
                  o.status = ST_OK;
                  break;
               end
            end
         end
         CMD_EMPTY: begin
            emptied = 1'b1;
         end
         default: begin
         end
      endcase
      o.is_empty    = emptied || held == 0;
      o.entry_count = ENTRY_COUNT_W'(held);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         held       = 0;
         emptied    = 1'b0;
         horizon    = '1;
         mismatches = 0;
         words_seen = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_head_time, rsp_head_id, rsp_is_empty, rsp_entry_count};
            words_seen++;
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d not expected: status %0d time %h id %h empty %b count %0d",
                           words_seen, seen.status, seen.head_time, seen.head_id,
                           seen.is_empty, seen.entry_count);
            end else begin
               want = awaited_outcomes[0];
               awaited_outcomes.delete(0);
               if (seen.status !== want.status || seen.head_time !== want.head_time ||
                   seen.head_id !== want.head_id || seen.is_empty !== want.is_empty ||
                   seen.entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("result word %0d: expected status %0d time %h id %h",
                            words_seen, want.status, want.head_time, want.head_id);
                     $write(" empty %b count %0d, got status %0d time %h",
                            want.is_empty, want.entry_count, seen.status, seen.head_time);
                     $display(" id %h empty %b count %0d",
                              seen.head_id, seen.is_empty, seen.entry_count);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_outcomes.push_back(schedule_step(req_command, req_event_time,
                                                     req_event_id));
         if (csr_write_en) horizon = csr_write_data;
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

[tb/sv/time_ordered_event_queue_tb.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue_tb
// Drives command words with random gaps and result stalls through phases of
// different end times: a directed opening, insert-heavy and drain-heavy
// random phases with long receiver hold-offs, and a closing phase with the
// sticky emptied flag. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_tb;
   import teq_pkg::*;

   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 2 * QUEUE_DEPTH_DEFAULT + 40;
   localparam int PHASE_WORDS = 125;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command     = CMD_PEEK;
   logic [TIME_W-1:0]        req_event_time  = '0;
   logic [ID_W-1:0]          req_event_id    = '0;
   logic                     csr_write_en    = 1'b0;
   logic [TIME_W-1:0]        csr_write_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [TIME_W-1:0]        rsp_head_time;
   logic [ID_W-1:0]          rsp_head_id;
   logic                     rsp_is_empty;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;
   int                       mismatches;
   int                       outstanding;

   int                send_run  = 0;
   int                take_run  = 0;
   int                taken     = 0;
   int                quiet     = 0;
   logic [TIME_W-1:0] horizon_now = '1;

   time_ordered_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH_DEFAULT)) dut (.*);

   time_ordered_event_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH_DEFAULT)) tracker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stretches of zero gaps now and then
   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         run_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                            input logic [ID_W-1:0] id);
      int gap;
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_event_time <= t;
      req_event_id   <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_queue();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic set_horizon(input logic [TIME_W-1:0] value);
      drain_queue();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      horizon_now     = value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      // a small id pool so that removes find their target
      if ($urandom_range(0, 9) < 8) return ID_W'($urandom_range(0, 31));
      return ID_W'($urandom);
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 13) return TIME_W'($urandom_range(0, 63));
      if (pick < 16) return TIME_W'($urandom);
      return horizon_now + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
   endfunction

   task automatic random_phase(input int count, input bit filling);
      int               done;
      int               pick;
      logic [CMD_W-1:0] cmd;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 60 : 30)) cmd = CMD_INSERT;
         else if (pick < (filling ? 72 : 62)) cmd = CMD_POP;
         else if (pick < (filling ? 87 : 86)) cmd = CMD_REMOVE;
         else if (pick < 97) cmd = CMD_PEEK;
         else cmd = CMD_EMPTY + CMD_W'($urandom_range(1, 3));
         if (cmd == CMD_INSERT) send_word(cmd, pick_time(), pick_id());
         else if (cmd == CMD_REMOVE) send_word(cmd, TIME_W'($urandom), pick_id());
         else send_word(cmd, TIME_W'($urandom), ID_W'($urandom));
         if (cmd <= CMD_EMPTY) done++;
      end
   endtask

   // receiver: random stalls, plus long hold-offs that back the block up
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 250 || taken == 700 || taken == 1100) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(take_run);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= IDLE_LIMIT) begin
         $display("time_ordered_event_queue_tb NOT OK");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] end_choice;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, stable order on equal times, extremes, duplicate ids
      set_horizon('1);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_PEEK, '1, '1);
      send_word(CMD_REMOVE, '0, 16'h1234);
      send_word(CMD_INSERT, 32'd5, 16'd1);
      send_word(CMD_INSERT, 32'd5, 16'd2);
      send_word(CMD_INSERT, '0, '1);
      send_word(CMD_INSERT, '1, '0);
      send_word(CMD_INSERT, 32'd3, 16'd7);
      send_word(CMD_INSERT, 32'd5, 16'd7);
      send_word(CMD_PEEK, '0, '0);
      send_word(CMD_REMOVE, '0, 16'd2);
      send_word(CMD_REMOVE, '0, 16'd99);
      send_word(CMD_REMOVE, '0, 16'd7);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_EMPTY + CMD_W'(1), '1, '1);
      send_word(CMD_EMPTY + CMD_W'(2), '1, '1);
      send_word(CMD_EMPTY + CMD_W'(3), '1, '1);
      // end time boundary
      set_horizon(32'd100);
      send_word(CMD_INSERT, 32'd101, 16'd3);
      send_word(CMD_INSERT, 32'd100, 16'd4);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 5)
            0:       end_choice = '1;
            1:       end_choice = 32'd40;
            2:       end_choice = '0;
            3:       end_choice = TIME_W'($urandom_range(10, 63));
            default: end_choice = TIME_W'($urandom);
         endcase
         set_horizon(end_choice);
         random_phase(PHASE_WORDS, phase % 2 == 0);
      end

      // emptied flag is sticky, so it comes last
      set_horizon(32'd50);
      send_word(CMD_EMPTY, '0, '0);
      random_phase(20, 1'b1);
      send_word(CMD_EMPTY, '1, '1);
      random_phase(20, 1'b0);

      drain_queue();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("time_ordered_event_queue_tb OK");
      end else begin
         $display("time_ordered_event_queue_tb NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/teq_pkg.sv
hdl/teq_ctrl.sv
hdl/teq_dpath.sv
hdl/time_ordered_event_queue.sv
hdl/teq_checker.sv
tb/sv/time_ordered_event_queue_checker.sv
tb/sv/time_ordered_event_queue_tb.sv
